// ----- rtl/core/csdm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csdm_pkg
// Shared constants, payload types and the arctangent table for the
// concentric square-to-disc map.
// ----------------------------------------------------------------------------
package csdm_pkg;

    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 32;
    localparam int RUN_STAGES    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int IDX_W         = $clog2(MAX_STAGES);

    localparam int COORD_W  = 16;                 // field width
    localparam int MAG_W    = COORD_W;            // magnitude / divisor width
    localparam int ANG_BITS = 30;                 // Q30 angles and CORDIC values
    localparam int QBITS    = ANG_BITS + 1;       // ratio, at most 1.0 in Q30
    localparam int CS_W     = ANG_BITS + 2;       // CORDIC x, y, z
    localparam int TH_PROD_W = QBITS + ANG_BITS;  // ratio times pi/4
    localparam int PROD_W   = COORD_W + CS_W;     // radius times cos/sin
    localparam int RND_W    = PROD_W - ANG_BITS;  // scaled result before clamp

    localparam int ONE = 1 << FRAC_BITS;

    localparam logic [ANG_BITS-1:0]         PI4_Q30  = ANG_BITS'(843314857);
    localparam logic signed [CS_W-1:0]      GAIN_Q30 = CS_W'(652032874);
    localparam logic [TH_PROD_W-1:0]        TH_HALF  = TH_PROD_W'(1) << (ANG_BITS - 1);
    localparam logic signed [PROD_W-1:0]    RND_HALF = PROD_W'(1) << (ANG_BITS - 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] den;   // radius
        logic                      first; // |a| > |b|
    } side_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;   // partial remainder
        logic [QBITS-1:0] w;     // dividend bits out on top, quotient bits in below
        logic [MAG_W-1:0] md;    // divisor
        logic             neg;   // angle sign
        side_t            side;
    } div_t;

    typedef struct packed {
        logic signed [CS_W-1:0] x;
        logic signed [CS_W-1:0] y;
        logic signed [CS_W-1:0] z;
        side_t                  side;
    } cor_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [CS_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
        logic [ANG_BITS-1:0] v;
        case (i)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            5'd24:   v = 30'd63;
            5'd25:   v = 30'd31;
            5'd26:   v = 30'd15;
            5'd27:   v = 30'd7;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = '0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

// ----- rtl/core/csdm_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csdm_div_cell
// One restoring-division cell: produces one quotient bit of the ratio.
// ----------------------------------------------------------------------------
module csdm_div_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            vld_in,
    input  csdm_pkg::div_t  d_in,
    output logic            vld_out,
    output csdm_pkg::div_t  d_out
);

    logic [csdm_pkg::MAG_W:0] trial;
    logic                     ge;
    csdm_pkg::div_t           d_next;
    csdm_pkg::div_t           d_reg;
    logic                     vld_reg;

    always_comb
    begin
        trial  = {d_in.rem, d_in.w[csdm_pkg::QBITS-1]};
        ge     = (trial >= {1'b0, d_in.md});
        d_next = d_in;
        if (ge)
        begin
            d_next.rem = csdm_pkg::MAG_W'(trial - {1'b0, d_in.md});
        end
        else
        begin
            d_next.rem = trial[csdm_pkg::MAG_W-1:0];
        end
        d_next.w = {d_in.w[csdm_pkg::QBITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule

// ----- rtl/core/csdm_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csdm_cordic_cell
// One CORDIC rotation-mode micro-rotation; stage index tied by the caller.
// ----------------------------------------------------------------------------
module csdm_cordic_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [csdm_pkg::IDX_W-1:0]    idx,
    input  logic                          vld_in,
    input  csdm_pkg::cor_t                c_in,
    output logic                          vld_out,
    output csdm_pkg::cor_t                c_out
);

    logic signed [csdm_pkg::CS_W-1:0] dx;
    logic signed [csdm_pkg::CS_W-1:0] dy;
    logic signed [csdm_pkg::CS_W-1:0] ang;
    csdm_pkg::cor_t                   c_next;
    csdm_pkg::cor_t                   c_reg;
    logic                             vld_reg;

    always_comb
    begin
        dx     = c_in.y >>> idx;
        dy     = c_in.x >>> idx;
        ang    = csdm_pkg::atan_q30(idx);
        c_next = c_in;
        if (!c_in.z[csdm_pkg::CS_W-1])
        begin
            c_next.x = c_in.x - dx;
            c_next.y = c_in.y + dy;
            c_next.z = c_in.z - ang;
        end
        else
        begin
            c_next.x = c_in.x + dx;
            c_next.y = c_in.y - dy;
            c_next.z = c_in.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg <= c_next;
        end
    end

    assign vld_out = vld_reg;
    assign c_out   = c_reg;

endmodule

// ----- rtl/core/concentric_square_to_disc_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// concentric_square_to_disc_map
// Maps a square sample (a, b) in [-1,1]^2 onto the unit disc with the
// concentric low-distortion mapping, one request per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid/in_ready carries a_coord, b_coord (s1.14).
//   Output channel out_valid/out_ready carries u_coord, v_coord (s1.14).
//   Inputs outside [-1,1] are clamped first; (0,0) maps to (0,0).
//   Throughput: one request per cycle unless stalled. The chain is one
//   divider cell per ratio bit, one multiply for the angle, one CORDIC
//   cell per stage and one multiply for the radius; every stage holds one
//   request.
//   Stall: the output register holds its result while out_ready is low.
//   The chain keeps moving (and in_ready stays high) as long as its last
//   stage is empty; otherwise it freezes until the output register drains.
//   Reset clears every valid bit; nothing else needs clearing.
// ----------------------------------------------------------------------------
module concentric_square_to_disc_map
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [csdm_pkg::COORD_W-1:0]  a_coord,
    input  logic signed [csdm_pkg::COORD_W-1:0]  b_coord,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [csdm_pkg::COORD_W-1:0]  u_coord,
    output logic signed [csdm_pkg::COORD_W-1:0]  v_coord
);

    localparam int QB = csdm_pkg::QBITS;
    localparam int NS = csdm_pkg::RUN_STAGES;

    // ------------------------------------------------------------------
    // Flow control: one enable for the whole chain
    // ------------------------------------------------------------------
    logic out_load;
    logic adv;
    logic last_vld;

    // ------------------------------------------------------------------
    // Front end: clamp, fold into an octant, set up the divider
    // ------------------------------------------------------------------
    logic signed [csdm_pkg::COORD_W-1:0] a_sat;
    logic signed [csdm_pkg::COORD_W-1:0] b_sat;
    logic [csdm_pkg::MAG_W-1:0]          a_abs;
    logic [csdm_pkg::MAG_W-1:0]          b_abs;
    logic                                first;
    logic signed [csdm_pkg::COORD_W-1:0] num;
    logic signed [csdm_pkg::COORD_W-1:0] den;
    logic [csdm_pkg::MAG_W-1:0]          mn;
    logic [csdm_pkg::MAG_W-1:0]          md;
    csdm_pkg::div_t                      prep_next;

    always_comb
    begin
        if (a_coord > csdm_pkg::ONE)
        begin
            a_sat = csdm_pkg::COORD_W'(csdm_pkg::ONE);
        end
        else if (a_coord < -csdm_pkg::ONE)
        begin
            a_sat = csdm_pkg::COORD_W'(-csdm_pkg::ONE);
        end
        else
        begin
            a_sat = a_coord;
        end

        if (b_coord > csdm_pkg::ONE)
        begin
            b_sat = csdm_pkg::COORD_W'(csdm_pkg::ONE);
        end
        else if (b_coord < -csdm_pkg::ONE)
        begin
            b_sat = csdm_pkg::COORD_W'(-csdm_pkg::ONE);
        end
        else
        begin
            b_sat = b_coord;
        end

        a_abs = a_sat[csdm_pkg::COORD_W-1] ? csdm_pkg::MAG_W'(-a_sat) : csdm_pkg::MAG_W'(a_sat);
        b_abs = b_sat[csdm_pkg::COORD_W-1] ? csdm_pkg::MAG_W'(-b_sat) : csdm_pkg::MAG_W'(b_sat);

        // equal magnitudes take the b-radius branch
        first = (a_abs > b_abs);
        num   = first ? b_sat : a_sat;
        den   = first ? a_sat : b_sat;
        mn    = first ? b_abs : a_abs;
        md    = first ? a_abs : b_abs;

        // dividend = mn * 2^30 + md/2; top bits seed the remainder
        prep_next.rem        = mn >> 1;
        prep_next.w          = {mn[0], csdm_pkg::ANG_BITS'(md >> 1)};
        prep_next.md         = md;
        prep_next.neg        = num[csdm_pkg::COORD_W-1] ^ den[csdm_pkg::COORD_W-1];
        prep_next.side.den   = den;
        prep_next.side.first = first;
    end

    // ------------------------------------------------------------------
    // Divider chain: index 0 is the front-end register
    // ------------------------------------------------------------------
    csdm_pkg::div_t div_d [0:QB];
    logic           div_v [0:QB];
    csdm_pkg::div_t prep_reg;
    logic           prep_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            prep_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_reg <= prep_next;
        end
    end

    assign div_d[0] = prep_reg;
    assign div_v[0] = prep_vld_reg;

    genvar gd;
    generate
        for (gd = 0; gd < QB; gd++)
        begin : g_div
            csdm_div_cell u_div_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .vld_in  (div_v[gd]),
                .d_in    (div_d[gd]),
                .vld_out (div_v[gd+1]),
                .d_out   (div_d[gd+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Angle: q * pi/4, then round and apply the sign
    // ------------------------------------------------------------------
    logic [csdm_pkg::TH_PROD_W-1:0]   mul_prod_reg;
    logic                             mul_neg_reg;
    csdm_pkg::side_t                  mul_side_reg;
    logic                             mul_vld_reg;
    logic [csdm_pkg::TH_PROD_W-1:0]   th_sum;
    logic [QB-1:0]                    th_mag;
    logic signed [csdm_pkg::CS_W-1:0] theta;
    csdm_pkg::cor_t                   cor_next;
    csdm_pkg::cor_t                   ang_reg;
    logic                             ang_vld_reg;

    always_comb
    begin
        th_sum = mul_prod_reg + csdm_pkg::TH_HALF;
        th_mag = th_sum[csdm_pkg::TH_PROD_W-1:csdm_pkg::ANG_BITS];
        if (mul_neg_reg)
        begin
            theta = -$signed({1'b0, th_mag});
        end
        else
        begin
            theta = $signed({1'b0, th_mag});
        end
        cor_next.x    = csdm_pkg::GAIN_Q30;
        cor_next.y    = '0;
        cor_next.z    = theta;
        cor_next.side = mul_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            ang_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_vld_reg <= div_v[QB];
            ang_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_prod_reg <= csdm_pkg::TH_PROD_W'(div_d[QB].w) *
                            csdm_pkg::TH_PROD_W'(csdm_pkg::PI4_Q30);
            mul_neg_reg  <= div_d[QB].neg;
            mul_side_reg <= div_d[QB].side;
            ang_reg      <= cor_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chain
    // ------------------------------------------------------------------
    csdm_pkg::cor_t cor_d [0:NS];
    logic           cor_v [0:NS];

    assign cor_d[0] = ang_reg;
    assign cor_v[0] = ang_vld_reg;

    genvar gc;
    generate
        for (gc = 0; gc < NS; gc++)
        begin : g_cordic
            csdm_cordic_cell u_cordic_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .idx     (csdm_pkg::IDX_W'(gc)),
                .vld_in  (cor_v[gc]),
                .c_in    (cor_d[gc]),
                .vld_out (cor_v[gc+1]),
                .c_out   (cor_d[gc+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Radius scaling; the b-branch swaps cos and sin
    // ------------------------------------------------------------------
    logic signed [csdm_pkg::CS_W-1:0]   cs_u;
    logic signed [csdm_pkg::CS_W-1:0]   cs_v;
    logic signed [csdm_pkg::PROD_W-1:0] pu_reg;
    logic signed [csdm_pkg::PROD_W-1:0] pv_reg;
    logic                               scl_vld_reg;
    logic signed [csdm_pkg::PROD_W-1:0] su;
    logic signed [csdm_pkg::PROD_W-1:0] sv;
    logic signed [csdm_pkg::RND_W-1:0]  ru;
    logic signed [csdm_pkg::RND_W-1:0]  rv;
    logic signed [csdm_pkg::COORD_W-1:0] u_next;
    logic signed [csdm_pkg::COORD_W-1:0] v_next;
    logic signed [csdm_pkg::COORD_W-1:0] u_reg;
    logic signed [csdm_pkg::COORD_W-1:0] v_reg;
    logic                                out_vld_reg;

    always_comb
    begin
        cs_u = cor_d[NS].side.first ? cor_d[NS].x : cor_d[NS].y;
        cs_v = cor_d[NS].side.first ? cor_d[NS].y : cor_d[NS].x;
    end

    always_comb
    begin
        su = pu_reg + csdm_pkg::RND_HALF;
        sv = pv_reg + csdm_pkg::RND_HALF;
        ru = su[csdm_pkg::PROD_W-1:csdm_pkg::ANG_BITS];
        rv = sv[csdm_pkg::PROD_W-1:csdm_pkg::ANG_BITS];

        if (ru > csdm_pkg::ONE)
        begin
            u_next = csdm_pkg::COORD_W'(csdm_pkg::ONE);
        end
        else if (ru < -csdm_pkg::ONE)
        begin
            u_next = csdm_pkg::COORD_W'(-csdm_pkg::ONE);
        end
        else
        begin
            u_next = ru[csdm_pkg::COORD_W-1:0];
        end

        if (rv > csdm_pkg::ONE)
        begin
            v_next = csdm_pkg::COORD_W'(csdm_pkg::ONE);
        end
        else if (rv < -csdm_pkg::ONE)
        begin
            v_next = csdm_pkg::COORD_W'(-csdm_pkg::ONE);
        end
        else
        begin
            v_next = rv[csdm_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            scl_vld_reg <= cor_v[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pu_reg <= csdm_pkg::PROD_W'(cor_d[NS].side.den) *
                      csdm_pkg::PROD_W'(cs_u);
            pv_reg <= csdm_pkg::PROD_W'(cor_d[NS].side.den) *
                      csdm_pkg::PROD_W'(cs_v);
        end
    end

    // ------------------------------------------------------------------
    // Output register and chain enable
    // ------------------------------------------------------------------
    assign last_vld = scl_vld_reg;
    assign out_load = !out_vld_reg || out_ready;
    assign adv      = out_load || !last_vld;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= last_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && last_vld)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign u_coord   = u_reg;
    assign v_coord   = v_reg;

`ifndef SYNTHESIS
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (u_coord <= csdm_pkg::ONE && u_coord >= -csdm_pkg::ONE &&
                       v_coord <= csdm_pkg::ONE && v_coord >= -csdm_pkg::ONE))
        else $error("disc point outside unit range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_vld_reg && !out_ready && scl_vld_reg))
        else $error("input stalled without a blocked result");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        div_v[QB] |-> (div_d[QB].md == '0 || div_d[QB].rem < div_d[QB].md))
        else $error("divider remainder not below divisor");

    // the origin runs at about pi/2 with a zero radius, so its cosine may dip below zero
    a_cos_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cor_v[NS] && cor_d[NS].side.den != '0) |-> !cor_d[NS].x[csdm_pkg::CS_W-1])
        else $error("CORDIC cosine negative for octant angle");
`endif

endmodule
